>>> src/urlpd_pkg.sv
// Package: shared types, character and error codes, hex digit decode for the URL decoder.
`default_nettype none

package urlpd_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] err_type;

   localparam err_type ERR_NONE      = 2'd0;
   localparam err_type ERR_MALFORMED = 2'd1;
   localparam err_type ERR_DEC_NUL   = 2'd2;
   localparam err_type ERR_EMB_NUL   = 2'd3;

   localparam byte_type CH_PERCENT = 8'h25;
   localparam byte_type CH_PLUS    = 8'h2B;
   localparam byte_type CH_SPACE   = 8'h20;
   localparam byte_type CH_NUL     = 8'h00;

   typedef struct packed {
      logic       bad;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input byte_type c);
      hex_type r;
      byte_type t;
      r.bad   = 1'b0;
      r.value = 4'd0;
      t       = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
         t = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         t = c - 8'h37;
      end else if (c inside {[8'h61:8'h66]}) begin
         t = c - 8'h57;
      end else begin
         r.bad = 1'b1;
      end
      r.value = t[3:0];
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/urlpd_req_if.sv
// Interface: input channel of the URL decoder, one raw byte per item.
`default_nettype none

interface urlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   logic       plus_as_space;

   modport source (output valid, output data_byte, output last, output plus_as_space,
                   input ready);
   modport sink   (input valid, input data_byte, input last, input plus_as_space,
                   output ready);
endinterface

`default_nettype wire

>>> src/urlpd_rsp_if.sv
// Interface: result channel of the URL decoder, one result per item.
`default_nettype none

interface urlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_char;
   logic [1:0] error_code;
   logic       end_of_string;

   modport source (output valid, output out_valid, output out_char, output error_code,
                   output end_of_string, input ready);
   modport sink   (input valid, input out_valid, input out_char, input error_code,
                   input end_of_string, output ready);
endinterface

`default_nettype wire

>>> src/url_percent_decoder.sv
// Top level: streaming percent-encoded string decoder with sticky error status.
// The result of an accepted item is in the output register in the next cycle.
// Throughput: one item per cycle while each result is taken; the escape phase and nibble registers decode in one pass.
// req_chan.ready is high whenever the output register is empty or being taken.
// Reset: synchronous, clears escape phase, high nibble, sticky error and the result channel valid.
`default_nettype none

module url_percent_decoder
   import urlpd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   urlpd_req_if.sink   req_chan,
   urlpd_rsp_if.source rsp_chan
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] nibble_ff, nibble_in;
   err_type    err_ff, err_in;

   logic       rsp_valid_ff;
   logic       out_valid_ff, out_valid_in;
   byte_type   out_char_ff, out_char_in;
   err_type    out_err_ff;
   logic       out_eos_ff;

   logic       accept;
   hex_type    hd;
   logic [7:0] dec_byte;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign hd             = hex_digit(req_chan.data_byte);
   assign dec_byte       = {nibble_ff, hd.value};

   always_comb begin
      phase_in     = phase_ff;
      nibble_in    = nibble_ff;
      err_in       = err_ff;
      out_valid_in = 1'b0;
      out_char_in  = CH_NUL;
      if (err_ff == ERR_NONE) begin
         case (phase_ff)
            PH_HIGH: begin
               if (hd.bad || req_chan.last) begin
                  err_in = ERR_MALFORMED;
               end else begin
                  nibble_in = hd.value;
                  phase_in  = PH_LOW;
               end
            end
            PH_LOW: begin
               phase_in = PH_IDLE;
               if (hd.bad) begin
                  err_in = ERR_MALFORMED;
               end else if (dec_byte == CH_NUL) begin
                  err_in = ERR_DEC_NUL;
               end else begin
                  out_valid_in = 1'b1;
                  out_char_in  = dec_byte;
               end
            end
            default: begin
               if (req_chan.data_byte == CH_PERCENT) begin
                  if (req_chan.last) begin
                     err_in = ERR_MALFORMED;
                  end else begin
                     phase_in = PH_HIGH;
                  end
               end else if (req_chan.data_byte == CH_PLUS && req_chan.plus_as_space) begin
                  out_valid_in = 1'b1;
                  out_char_in  = CH_SPACE;
               end else if (req_chan.data_byte == CH_NUL) begin
                  err_in = ERR_EMB_NUL;
               end else begin
                  out_valid_in = 1'b1;
                  out_char_in  = req_chan.data_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         nibble_ff    <= 4'd0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            if (req_chan.last) begin
               phase_ff  <= PH_IDLE;
               nibble_ff <= 4'd0;
               err_ff    <= ERR_NONE;
            end else begin
               phase_ff  <= phase_in;
               nibble_ff <= nibble_in;
               err_ff    <= err_in;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_valid_ff <= out_valid_in;
         out_char_ff  <= out_char_in;
         out_err_ff   <= err_in;
         out_eos_ff   <= req_chan.last;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_valid     = out_valid_ff;
   assign rsp_chan.out_char      = out_char_ff;
   assign rsp_chan.error_code    = out_err_ff;
   assign rsp_chan.end_of_string = out_eos_ff;

   a_valid_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_valid |-> rsp_chan.error_code == ERR_NONE)
      else $error("decoded byte emitted with an error set");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.out_valid |-> rsp_chan.out_char == CH_NUL)
      else $error("out_char nonzero on an item without a byte");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last |=> phase_ff == PH_IDLE && err_ff == ERR_NONE)
      else $error("state not cleared after end of string");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && !req_chan.last && err_ff != ERR_NONE |=> $stable(err_ff))
      else $error("sticky error changed within a string");

endmodule

`default_nettype wire
